// ===== rtl/psq_pkg.sv =====
// Shared types and constants for the precharge and contactor sequencer.
package psq_pkg;

  localparam int unsigned READING_W = 20;
  localparam int unsigned PERCENT_W = 7;
  localparam int unsigned SENSOR_COUNT = 5;
  // Width of bus_voltage * 100 and of nominal * percent (both below 2**27).
  localparam int unsigned LEVEL_W = READING_W + PERCENT_W;

  localparam logic [SENSOR_COUNT-1:0] ALL_HEALTHY = '1;
  localparam logic [PERCENT_W-1:0] PERCENT_SCALE = 7'd100;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MOTOR_LIMIT = 3'd0;
  localparam logic [2:0] CFG_BUS_LIMIT = 3'd1;
  localparam logic [2:0] CFG_OV_LIMIT = 3'd2;
  localparam logic [2:0] CFG_UV_LIMIT = 3'd3;
  localparam logic [2:0] CFG_NOMINAL = 3'd4;
  localparam logic [2:0] CFG_PERCENT = 3'd5;

  typedef enum logic [1:0] {
    MODE_PRECHARGE = 2'd0,
    MODE_NORMAL    = 2'd1,
    MODE_FAULT     = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    FAULT_CLEAR     = 3'd0,
    FAULT_SENSOR    = 3'd1,
    FAULT_MOTOR_OC  = 3'd2,
    FAULT_BUS_OC    = 3'd3,
    FAULT_OVERVOLT  = 3'd4,
    FAULT_UNDERVOLT = 3'd5
  } fault_t;

  // Thresholds as seen by the evaluation logic.
  typedef struct packed {
    logic signed [READING_W-1:0] motor_limit;
    logic signed [READING_W-1:0] bus_limit;
    logic [READING_W-1:0]        ov_limit;
    logic [READING_W-1:0]        uv_limit;
    logic [LEVEL_W-1:0]          finish_level;
  } cfg_t;

  // One sensor poll.
  typedef struct packed {
    logic signed [READING_W-1:0] motor_one;
    logic signed [READING_W-1:0] motor_two;
    logic signed [READING_W-1:0] motor_three;
    logic signed [READING_W-1:0] motor_four;
    logic signed [READING_W-1:0] bus_current;
    logic [READING_W-1:0]        bus_voltage;
    logic [SENSOR_COUNT-1:0]     read_ok;
  } poll_t;

  // Sequencer state.
  typedef struct packed {
    mode_t                   mode;
    fault_t                  fault;
    logic [SENSOR_COUNT-1:0] health;
  } seq_state_t;

  // Output drive derived from the mode at the start of a poll.
  typedef struct packed {
    logic contactor_closed;
    logic motor_power_off_n;
  } drive_t;

endpackage

// ===== rtl/psq_cfg.sv =====
// Configuration registers and the registered precharge finish level.
module psq_cfg import psq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [READING_W-1:0]   cfg_data,
  output cfg_t                   cfg
);

  logic signed [READING_W-1:0] motor_limit;
  logic signed [READING_W-1:0] bus_limit;
  logic [READING_W-1:0]        ov_limit;
  logic [READING_W-1:0]        uv_limit;
  logic [READING_W-1:0]        nominal;
  logic [PERCENT_W-1:0]        percent;
  logic [LEVEL_W-1:0]          finish_level;

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      motor_limit <= {1'b0, {(READING_W-1){1'b1}}};
      bus_limit   <= {1'b0, {(READING_W-1){1'b1}}};
      ov_limit    <= '1;
      uv_limit    <= '0;
      nominal     <= '1;
      percent     <= 7'd95;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MOTOR_LIMIT: motor_limit <= $signed(cfg_data);
        CFG_BUS_LIMIT:   bus_limit   <= $signed(cfg_data);
        CFG_OV_LIMIT:    ov_limit    <= cfg_data;
        CFG_UV_LIMIT:    uv_limit    <= cfg_data;
        CFG_NOMINAL:     nominal     <= cfg_data;
        CFG_PERCENT:     percent     <= cfg_data[PERCENT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The finish level only changes with configuration, so the product is
  // refreshed every cycle and kept out of the per-poll path.
  always_ff @(posedge clk) begin
    finish_level <= LEVEL_W'(nominal) * LEVEL_W'(percent);
  end

  assign cfg.motor_limit  = motor_limit;
  assign cfg.bus_limit    = bus_limit;
  assign cfg.ov_limit     = ov_limit;
  assign cfg.uv_limit     = uv_limit;
  assign cfg.finish_level = finish_level;

endmodule

// ===== rtl/psq_eval.sv =====
// Single-pass evaluation of one poll: fault checks, next state and drive.
module psq_eval import psq_pkg::*; (
  input  cfg_t       cfg,
  input  poll_t      poll,
  input  seq_state_t cur,
  output seq_state_t nxt,
  output drive_t     drive
);

  logic [SENSOR_COUNT-1:0] health_next;
  logic                    motor_oc;
  logic                    bus_oc;
  logic                    over_volt;
  logic                    under_volt;
  logic [LEVEL_W-1:0]      bus_level;
  logic                    charged;
  fault_t                  check_fault;

  // Sticky health update happens in every mode.
  assign health_next = cur.health & poll.read_ok;

  // Individual limit checks.
  assign motor_oc   = (poll.motor_one > cfg.motor_limit) ||
                      (poll.motor_two > cfg.motor_limit) ||
                      (poll.motor_three > cfg.motor_limit) ||
                      (poll.motor_four > cfg.motor_limit);
  assign bus_oc     = poll.bus_current > cfg.bus_limit;
  assign over_volt  = poll.bus_voltage > cfg.ov_limit;
  assign under_volt = poll.bus_voltage < cfg.uv_limit;

  // Exact compare of voltage * 100 against nominal * percent.
  assign bus_level = LEVEL_W'(poll.bus_voltage) * LEVEL_W'(PERCENT_SCALE);
  assign charged   = bus_level >= cfg.finish_level;

  // First failing check in priority order.
  always_comb begin
    if (health_next != ALL_HEALTHY) begin
      check_fault = FAULT_SENSOR;
    end else if (motor_oc) begin
      check_fault = FAULT_MOTOR_OC;
    end else if (bus_oc) begin
      check_fault = FAULT_BUS_OC;
    end else if (over_volt) begin
      check_fault = FAULT_OVERVOLT;
    end else if (under_volt) begin
      check_fault = FAULT_UNDERVOLT;
    end else begin
      check_fault = FAULT_CLEAR;
    end
  end

  // Next state: only precharge moves; normal and fault hold; an invalid mode goes to fault.
  always_comb begin
    nxt.health = health_next;
    nxt.mode   = cur.mode;
    nxt.fault  = cur.fault;
    unique case (cur.mode)
      MODE_PRECHARGE: begin
        if (check_fault != FAULT_CLEAR) begin
          nxt.mode  = MODE_FAULT;
          nxt.fault = check_fault;
        end else if (charged) begin
          nxt.mode = MODE_NORMAL;
        end
      end
      MODE_NORMAL: begin
      end
      MODE_FAULT: begin
      end
      default: begin
        nxt.mode  = MODE_FAULT;
        nxt.fault = FAULT_CLEAR;
      end
    endcase
  end

  // Drive follows the mode at the start of the poll.
  always_comb begin
    unique case (cur.mode)
      MODE_NORMAL: begin
        drive.contactor_closed  = 1'b1;
        drive.motor_power_off_n = 1'b0;
      end
      default: begin
        drive.contactor_closed  = 1'b0;
        drive.motor_power_off_n = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/precharge_contactor_sequencer.sv =====
// Top level of the DC bus precharge and contactor sequencer.
//
// Each input beat is one sensor poll. It is held in an input register,
// checked in one pass of compare logic against the configured limits, and
// its result beat goes to an output register when it is free or emptying.
// The block takes one poll per cycle as long as the result side keeps up;
// a result waiting at the output keeps the held poll in the input register,
// which then takes no new poll. The precharge finish level (nominal times
// percent) is a registered product refreshed from the configuration
// registers, so configuration must be written while no poll is in flight.
// Outputs contactor_closed and motor_power_off_n follow the mode before the
// poll; mode, fault_code and health_mask give the state after it.
module precharge_contactor_sequencer import psq_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [READING_W-1:0]         cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [READING_W-1:0]  motor_one_current,
  input  logic signed [READING_W-1:0]  motor_two_current,
  input  logic signed [READING_W-1:0]  motor_three_current,
  input  logic signed [READING_W-1:0]  motor_four_current,
  input  logic signed [READING_W-1:0]  bus_current_reading,
  input  logic [READING_W-1:0]         bus_voltage_reading,
  input  logic [SENSOR_COUNT-1:0]      read_ok_mask,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   mode,
  output logic [2:0]                   fault_code,
  output logic                         contactor_closed,
  output logic                         motor_power_off_n,
  output logic [SENSOR_COUNT-1:0]      health_mask
);

  cfg_t       cfg;
  poll_t      poll;
  logic       poll_full;
  logic       advance;
  seq_state_t state;
  seq_state_t state_next;
  drive_t     drive;

  psq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  psq_eval u_eval (
    .cfg   (cfg),
    .poll  (poll),
    .cur   (state),
    .nxt   (state_next),
    .drive (drive)
  );

  // A held poll moves on whenever the output register is free or emptying.
  assign advance  = poll_full && (!out_valid || out_ready);
  assign in_ready = !poll_full || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      poll_full <= 1'b1;
    end else if (advance) begin
      poll_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      poll.motor_one   <= motor_one_current;
      poll.motor_two   <= motor_two_current;
      poll.motor_three <= motor_three_current;
      poll.motor_four  <= motor_four_current;
      poll.bus_current <= bus_current_reading;
      poll.bus_voltage <= bus_voltage_reading;
      poll.read_ok     <= read_ok_mask;
    end
  end

  // Sequencer state commits as the poll's result is registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode   <= MODE_PRECHARGE;
      state.fault  <= FAULT_CLEAR;
      state.health <= ALL_HEALTHY;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode              <= state_next.mode;
      fault_code        <= state_next.fault;
      contactor_closed  <= drive.contactor_closed;
      motor_power_off_n <= drive.motor_power_off_n;
      health_mask       <= state_next.health;
    end
  end

  // Normal operation is only left through reset.
  assert property (@(posedge clk) disable iff (rst)
    state.mode == MODE_NORMAL |=> state.mode == MODE_NORMAL)
    else $error("sequencer left normal operation");

  // A latched fault code is only ever reported alongside fault mode.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && fault_code != FAULT_CLEAR) |-> mode == MODE_FAULT)
    else $error("fault code reported outside fault mode");

  // The contactor is closed exactly when motor_power_off_n is low.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (contactor_closed != motor_power_off_n))
    else $error("contactor and motor enable disagree");

  // State only changes when a poll result is registered.
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("sequencer state changed without a poll");

endmodule

// ===== dv/tb_precharge_contactor_sequencer.sv =====
// Self-checking testbench for the precharge and contactor sequencer.
module tb_precharge_contactor_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import psq_pkg::*;

  localparam int MAX_S = 524287;
  localparam int MIN_S = -524288;
  localparam int MAX_U = 1048575;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 3;

  // Limits as the block holds them, updated after each set of register writes.
  typedef struct {
    logic signed [READING_W-1:0] motor_lim;
    logic signed [READING_W-1:0] bus_lim;
    logic [READING_W-1:0]        ov_lim;
    logic [READING_W-1:0]        uv_lim;
    logic [READING_W-1:0]        nominal;
    logic [PERCENT_W-1:0]        percent;
  } limits_t;

  // What one poll is expected to report.
  typedef struct {
    mode_t                   mode;
    fault_t                  fault;
    logic                    contactor;
    logic                    power_off_n;
    logic [SENSOR_COUNT-1:0] health;
  } poll_status_t;

  // The event that ends the single precharge phase of the run.
  typedef enum int {
    EXIT_SENSOR, EXIT_MOTOR_OC, EXIT_BUS_OC, EXIT_OVERVOLT, EXIT_UNDERVOLT, EXIT_NORMAL
  } exit_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_MOTOR_LIMIT;
  logic [READING_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [READING_W-1:0] motor_one_current = '0;
  logic signed [READING_W-1:0] motor_two_current = '0;
  logic signed [READING_W-1:0] motor_three_current = '0;
  logic signed [READING_W-1:0] motor_four_current = '0;
  logic signed [READING_W-1:0] bus_current_reading = '0;
  logic [READING_W-1:0] bus_voltage_reading = '0;
  logic [SENSOR_COUNT-1:0] read_ok_mask = '1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] mode;
  logic [2:0] fault_code;
  logic contactor_closed;
  logic motor_power_off_n;
  logic [SENSOR_COUNT-1:0] health_mask;

  precharge_contactor_sequencer i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .motor_one_current   (motor_one_current),
    .motor_two_current   (motor_two_current),
    .motor_three_current (motor_three_current),
    .motor_four_current  (motor_four_current),
    .bus_current_reading (bus_current_reading),
    .bus_voltage_reading (bus_voltage_reading),
    .read_ok_mask        (read_ok_mask),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .mode                (mode),
    .fault_code          (fault_code),
    .contactor_closed    (contactor_closed),
    .motor_power_off_n   (motor_power_off_n),
    .health_mask         (health_mask)
  );

  // Clock with an 8 ns period.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Predictor state and limits, reset values of the block.
  limits_t dut_limits = '{MAX_S, MAX_S, MAX_U, 0, MAX_U, 95};
  mode_t pred_mode = MODE_PRECHARGE;
  fault_t pred_fault = FAULT_CLEAR;
  logic [SENSOR_COUNT-1:0] pred_health = ALL_HEALTHY;

  poll_t pending_polls[$];
  poll_status_t expected_status[$];
  poll_t poll_cur;

  int polls_pushed = 0;
  int polls_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int settings_loaded = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int stall_cycles = 0;
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;
  exit_kind_t exit_kind;

  // Random helpers.
  function automatic int rnd_between(int lo, int hi);
    return lo + int'($urandom_range(32'(hi - lo), 0));
  endfunction

  // Mostly short gaps, now and then a long one; none in a steady stretch.
  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(99, 0);
    if (steady || r < 65) return 0;
    if (r < 92) return rnd_between(1, 3);
    return rnd_between(8, 40);
  endfunction

  // Value in [lo, hi], with the two ends favoured.
  function automatic int pick_edgy(int lo, int hi);
    int r;
    r = $urandom_range(7, 0);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return rnd_between(lo, hi);
  endfunction

  // Smallest bus voltage that finishes precharge under the given limits.
  function automatic int finish_threshold(limits_t l);
    int prod;
    prod = int'(l.nominal) * int'(l.percent);
    return (prod + 99) / 100;
  endfunction

  // A poll that passes every check and stays below the finish level.
  function automatic poll_t hold_poll();
    poll_t p;
    int top;
    top = finish_threshold(dut_limits) - 1;
    if (int'(dut_limits.ov_lim) < top) top = int'(dut_limits.ov_lim);
    p.motor_one   = 20'(pick_edgy(MIN_S, int'(dut_limits.motor_lim)));
    p.motor_two   = 20'(pick_edgy(MIN_S, int'(dut_limits.motor_lim)));
    p.motor_three = 20'(pick_edgy(MIN_S, int'(dut_limits.motor_lim)));
    p.motor_four  = 20'(pick_edgy(MIN_S, int'(dut_limits.motor_lim)));
    p.bus_current = 20'(pick_edgy(MIN_S, int'(dut_limits.bus_lim)));
    p.bus_voltage = 20'(pick_edgy(int'(dut_limits.uv_lim), top));
    p.read_ok     = ALL_HEALTHY;
    return p;
  endfunction

  // A poll with every field random; reads mostly succeed.
  function automatic poll_t noise_poll();
    poll_t p;
    p.motor_one   = 20'($urandom());
    p.motor_two   = 20'($urandom());
    p.motor_three = 20'($urandom());
    p.motor_four  = 20'($urandom());
    p.bus_current = 20'($urandom());
    p.bus_voltage = 20'($urandom());
    p.read_ok     = ($urandom_range(3, 0) != 0) ? ALL_HEALTHY : 5'($urandom());
    return p;
  endfunction

  function automatic poll_t mk_poll(int m1, int m2, int m3, int m4, int bus, int volt);
    poll_t p;
    p.motor_one   = 20'(m1);
    p.motor_two   = 20'(m2);
    p.motor_three = 20'(m3);
    p.motor_four  = 20'(m4);
    p.bus_current = 20'(bus);
    p.bus_voltage = 20'(volt);
    p.read_ok     = ALL_HEALTHY;
    return p;
  endfunction

  // The poll that ends precharge. Checks of lower priority may fail too.
  function automatic poll_t exit_poll(exit_kind_t kind);
    poll_t p;
    poll_t n;
    int over;
    p = hold_poll();
    n = noise_poll();
    case (kind)
      EXIT_SENSOR: begin
        p = n;
        p.read_ok = 5'($urandom_range(30, 0));
      end
      EXIT_MOTOR_OC: begin
        over = rnd_between(int'(dut_limits.motor_lim) + 1, MAX_S);
        case ($urandom_range(3, 0))
          0: p.motor_one = 20'(over);
          1: p.motor_two = 20'(over);
          2: p.motor_three = 20'(over);
          default: p.motor_four = 20'(over);
        endcase
        p.bus_current = n.bus_current;
        p.bus_voltage = n.bus_voltage;
      end
      EXIT_BUS_OC: begin
        p.bus_current = 20'(rnd_between(int'(dut_limits.bus_lim) + 1, MAX_S));
        p.bus_voltage = n.bus_voltage;
      end
      EXIT_OVERVOLT: p.bus_voltage = 20'(rnd_between(int'(dut_limits.ov_lim) + 1, MAX_U));
      EXIT_UNDERVOLT: p.bus_voltage = 20'(rnd_between(0, int'(dut_limits.uv_lim) - 1));
      default: begin
        p.bus_voltage = 20'(pick_edgy(finish_threshold(dut_limits),
                                      int'(dut_limits.ov_lim)));
      end
    endcase
    return p;
  endfunction

  // Random limits under which precharge can still be held.
  function automatic limits_t random_limits();
    limits_t l;
    int thr;
    int top;
    l.motor_lim = 20'(pick_edgy(MIN_S, MAX_S));
    l.bus_lim   = 20'(pick_edgy(MIN_S, MAX_S));
    l.nominal   = 20'(pick_edgy(1, MAX_U));
    l.percent   = 7'(pick_edgy(1, 127));
    l.ov_lim    = 20'(pick_edgy(0, MAX_U));
    thr = finish_threshold(l);
    top = (int'(l.ov_lim) < thr - 1) ? int'(l.ov_lim) : thr - 1;
    l.uv_lim    = 20'(pick_edgy(0, top));
    return l;
  endfunction

  // Next state and outputs of the block for one accepted poll.
  task automatic predict_status(input poll_t p);
    mode_t start_mode;
    fault_t found;
    logic [33:0] bus_level;
    logic [33:0] finish_level;
    poll_status_t s;
    start_mode = pred_mode;
    pred_health = pred_health & p.read_ok;
    if (start_mode == MODE_PRECHARGE) begin
      bus_level = 34'(p.bus_voltage) * 34'd100;
      finish_level = 34'(dut_limits.nominal) * 34'(dut_limits.percent);
      if (pred_health != ALL_HEALTHY) begin
        found = FAULT_SENSOR;
      end else if (($signed(p.motor_one) > $signed(dut_limits.motor_lim)) ||
                   ($signed(p.motor_two) > $signed(dut_limits.motor_lim)) ||
                   ($signed(p.motor_three) > $signed(dut_limits.motor_lim)) ||
                   ($signed(p.motor_four) > $signed(dut_limits.motor_lim))) begin
        found = FAULT_MOTOR_OC;
      end else if ($signed(p.bus_current) > $signed(dut_limits.bus_lim)) begin
        found = FAULT_BUS_OC;
      end else if (p.bus_voltage > dut_limits.ov_lim) begin
        found = FAULT_OVERVOLT;
      end else if (p.bus_voltage < dut_limits.uv_lim) begin
        found = FAULT_UNDERVOLT;
      end else begin
        found = FAULT_CLEAR;
      end
      if (found != FAULT_CLEAR) begin
        pred_fault = found;
        pred_mode = MODE_FAULT;
      end else if (bus_level >= finish_level) begin
        pred_mode = MODE_NORMAL;
      end
    end
    s.mode = pred_mode;
    s.fault = pred_fault;
    s.contactor = (start_mode == MODE_NORMAL);
    s.power_off_n = (start_mode != MODE_NORMAL);
    s.health = pred_health;
    expected_status.push_back(s);
  endtask

  // Compare one result beat with the oldest expectation.
  task automatic check_status();
    poll_status_t want;
    results_seen++;
    if (expected_status.size() == 0) begin
      $error("result beat with no poll outstanding");
      mismatches++;
    end else begin
      want = expected_status.pop_front();
      if (mode !== want.mode) begin
        $error("mode: expected %0d, actual %0d", want.mode, mode);
        mismatches++;
      end
      if (fault_code !== want.fault) begin
        $error("fault_code: expected %0d, actual %0d", want.fault, fault_code);
        mismatches++;
      end
      if (contactor_closed !== want.contactor) begin
        $error("contactor_closed: expected %0b, actual %0b", want.contactor,
               contactor_closed);
        mismatches++;
      end
      if (motor_power_off_n !== want.power_off_n) begin
        $error("motor_power_off_n: expected %0b, actual %0b", want.power_off_n,
               motor_power_off_n);
        mismatches++;
      end
      if (health_mask !== want.health) begin
        $error("health_mask: expected %b, actual %b", want.health, health_mask);
        mismatches++;
      end
    end
  endtask

  // Sender: offers queued polls, with random gaps after each beat.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_status(poll_cur);
        polls_taken++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_polls.size() != 0) begin
        poll_cur = pending_polls.pop_front();
        motor_one_current <= poll_cur.motor_one;
        motor_two_current <= poll_cur.motor_two;
        motor_three_current <= poll_cur.motor_three;
        motor_four_current <= poll_cur.motor_four;
        bus_current_reading <= poll_cur.bus_current;
        bus_voltage_reading <= poll_cur.bus_voltage;
        read_ok_mask <= poll_cur.read_ok;
        in_valid <= 1'b1;
        send_gap = pick_gap(send_steady);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result beat and stalls at random or on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_status();
        recv_gap = pick_gap(recv_steady);
      end
      if (hold_served < hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither side moves a beat.
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  // Wait until every poll has been taken and every result has come back.
  task automatic settle();
    while (polls_taken != polls_pushed || expected_status.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [READING_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  // Write all six registers while the block is idle.
  task automatic load_limits(input limits_t l);
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    put_reg(CFG_MOTOR_LIMIT, l.motor_lim);
    put_reg(CFG_BUS_LIMIT, l.bus_lim);
    put_reg(CFG_OV_LIMIT, l.ov_lim);
    put_reg(CFG_UV_LIMIT, l.uv_lim);
    put_reg(CFG_NOMINAL, l.nominal);
    put_reg(CFG_PERCENT, 20'(l.percent));
    @(posedge clk);
    cfg_we <= 1'b0;
    dut_limits = l;
    settings_loaded++;
    // Let the registered finish level catch up before the next poll.
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    send_steady = ($urandom_range(3, 0) == 0);
    recv_steady = ($urandom_range(3, 0) == 0);
  endtask

  task automatic push_poll(input poll_t p);
    pending_polls.push_back(p);
    polls_pushed++;
  endtask

  // Stimulus sequence.
  initial begin
    limits_t l;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset limits: current extremes and the voltage just short of finishing.
    push_poll(mk_poll(0, 0, 0, 0, 0, 0));
    push_poll(mk_poll(MAX_S, MAX_S, MAX_S, MAX_S, MAX_S, 996146));
    push_poll(mk_poll(MIN_S, MIN_S, MIN_S, MIN_S, MIN_S, 524288));
    push_poll(mk_poll(MAX_S, -1, 'h55555, 'hAAAAA, -1, 'h55555));
    push_poll(mk_poll(-1, MAX_S, MIN_S, 0, 'h2AAAA, 'hAAAAA));

    // Lowest current limits, zero voltage window, percent at its top.
    load_limits('{MIN_S, MIN_S, 0, 0, MAX_U, 127});
    push_poll(mk_poll(MIN_S, MIN_S, MIN_S, MIN_S, MIN_S, 0));
    push_poll(mk_poll(MIN_S, MIN_S, MIN_S, MIN_S, MIN_S, 0));

    // Percent above 100 lets a full-scale bus voltage stay in precharge.
    load_limits('{0, 0, MAX_U, MAX_U, MAX_U, 127});
    push_poll(mk_poll(0, 0, 0, 0, 0, MAX_U));
    push_poll(mk_poll(MIN_S, 0, MIN_S, 0, MIN_S, MAX_U));

    // Voltage exactly on both limits; currents exactly on their limits.
    load_limits('{-1, -1, 500000, 500000, MAX_U, 100});
    push_poll(mk_poll(-1, -1, -1, -1, -1, 500000));
    push_poll(mk_poll(MIN_S, -1, MIN_S, -1, -1, 500000));

    // Smallest non-zero finish level: only a zero bus voltage holds.
    load_limits('{MAX_S, MAX_S, MAX_U, 0, 1, 1});
    push_poll(mk_poll(MAX_S, MIN_S, MAX_S, MIN_S, MAX_S, 0));

    // Random limits, each held for a run of well-formed polls.
    for (int ph = 0; ph < 9; ph++) begin
      load_limits(random_limits());
      if (ph == 3) begin
        // The receiver sits out a long stretch while polls keep coming.
        send_steady = 1'b1;
        hold_requests++;
      end
      for (int i = 0; i < 50; i++) push_poll(hold_poll());
    end

    // Limits under which every way out of precharge is possible.
    l.motor_lim = 20'(rnd_between(-1000, 500000));
    l.bus_lim   = 20'(rnd_between(-1000, 500000));
    l.uv_lim    = 20'(rnd_between(1, 150000));
    l.ov_lim    = 20'(rnd_between(1000001, MAX_U - 1));
    l.nominal   = 20'(rnd_between(400000, 1000000));
    l.percent   = 7'(rnd_between(50, 100));
    load_limits(l);
    exit_kind = exit_kind_t'($urandom_range(5, 0));
    for (int i = 0; i < 15; i++) push_poll(hold_poll());
    push_poll(exit_poll(exit_kind));
    for (int i = 0; i < 20; i++) push_poll(noise_poll());

    // Once out of precharge only the health mask moves, whatever the limits.
    load_limits('{MIN_S, MIN_S, 0, MAX_U, MAX_U, 0});
    for (int i = 0; i < 30; i++) push_poll(noise_poll());
    load_limits('{MAX_S, MAX_S, MAX_U, 0, 0, 100});
    for (int i = 0; i < 30; i++) push_poll(noise_poll());
    load_limits(random_limits());
    for (int i = 0; i < 30; i++) push_poll(noise_poll());

    // Drain, then wait for any stray beat.
    settle();
    repeat (10) @(posedge clk);
    $display("Run covered %0d polls, %0d result beats and %0d register settings.",
             polls_taken, results_seen, settings_loaded);
    $display("Precharge ended by %s; later polls drove the sticky health mask.",
             exit_kind.name());
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
